// File: src/tpack_pkg.sv
// Shared constants, types and helper functions of the ternary frame packer.
`default_nettype none
package tpack_pkg;

	// Cell grid and packing geometry
	localparam int OUT_WIDTH   = 80;
	localparam int OUT_HEIGHT  = 30;
	localparam int GROUP       = 5;
	localparam int CELLS       = OUT_WIDTH * OUT_HEIGHT;
	localparam int NBYTES      = (CELLS + GROUP - 1) / GROUP;
	localparam int LAST_DIGITS = CELLS - (NBYTES - 1) * GROUP;

	// Derived widths
	localparam int ADDR_W  = $clog2(CELLS);
	localparam int BASE_W  = $clog2(CELLS + 1);
	localparam int CX_W    = $clog2(OUT_WIDTH + 1);
	localparam int CY_W    = $clog2(OUT_HEIGHT + 1);
	localparam int COL_W   = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
	localparam int BYTE_W  = (NBYTES > 1) ? $clog2(NBYTES) : 1;
	localparam int K_W     = $clog2(GROUP);

	// Register and field widths
	localparam int SIZE_W  = 13;
	localparam int STEP_W  = 8;
	localparam int CODE_W  = 2;
	localparam int CHAN_W  = 8;
	localparam int BYTE_OUT_W = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_X       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_WHITE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_GREY    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_BLACK   = 3'd6;

	// Input mode codes
	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

	// Read address of the first drained cell: top row, left column
	localparam logic [ADDR_W-1:0] WALK_START = ADDR_W'((OUT_HEIGHT - 1) * OUT_WIDTH);

	// Stored cell class
	typedef enum logic [1:0] {
		CLS_BLACK = 2'd0,
		CLS_WHITE = 2'd1,
		CLS_GREY  = 2'd2
	} cls_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clr_wr;
		logic pix_wr;
		logic drn_start;
		logic rd_en;
		logic out_load;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_done;
		logic rd_last;
		logic out_busy;
	} sts_t;

	// Treat code three as two
	function automatic logic [CODE_W-1:0] clip_code(input logic [CODE_W-1:0] c);
		return (c == 2'd3) ? 2'd2 : c;
	endfunction

	// Base-3 place value of digit k
	function automatic logic [BYTE_OUT_W-1:0] weight_of(input logic [K_W-1:0] k);
		logic [BYTE_OUT_W-1:0] w;
		w = 8'd1;
		for (int i = 0; i < GROUP; i++) begin
			if (i < int'(k)) begin
				w = BYTE_OUT_W'(w * 8'd3);
			end
		end
		return w;
	endfunction

endpackage
`default_nettype wire

// File: src/tpack_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module tpack_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 2400
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: src/tpack_ctrl.sv
// Controller state machine of the ternary frame packer.
`default_nettype none
module tpack_ctrl import tpack_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic mode,
	input  wire sts_t sts,
	output logic      in_stall,
	output cmd_t      cmd
);

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_READ   = 5'b00100,
		S_SETTLE = 5'b01000,
		S_PUSH   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// Take input words only when idle
	assign in_stall = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					if (mode == MODE_DRAIN) begin
						cmd.drn_start = 1'b1;
						state_d       = S_READ;
					end else begin
						cmd.pix_wr = 1'b1;
					end
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				if (sts.rd_last) state_d = S_SETTLE;
			end
			S_SETTLE: begin
				state_d = S_PUSH;
			end
			S_PUSH: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// File: src/tpack_dp.sv
// Datapath: registers, position counters, cell store, drain walk and packer.
`default_nettype none
module tpack_dp import tpack_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output sts_t                       sts,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [CHAN_W-1:0]     blue,
	input  wire logic [CHAN_W-1:0]     green,
	input  wire logic [CHAN_W-1:0]     red,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [BYTE_OUT_W-1:0]      packed_byte,
	output logic                       last_byte
);

	// Configuration registers
	logic [SIZE_W-1:0] image_width_q, image_height_q;
	logic [STEP_W-1:0] step_x_q, step_y_q;
	logic [CODE_W-1:0] code_white_q, code_grey_q, code_black_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= SIZE_W'(640);
			image_height_q <= SIZE_W'(480);
			step_x_q       <= STEP_W'(8);
			step_y_q       <= STEP_W'(16);
			code_white_q   <= 2'd1;
			code_grey_q    <= 2'd2;
			code_black_q   <= 2'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				CFG_STEP_X:       step_x_q       <= cfg_data[STEP_W-1:0];
				CFG_STEP_Y:       step_y_q       <= cfg_data[STEP_W-1:0];
				CFG_CODE_WHITE:   code_white_q   <= cfg_data[CODE_W-1:0];
				CFG_CODE_GREY:    code_grey_q    <= cfg_data[CODE_W-1:0];
				CFG_CODE_BLACK:   code_black_q   <= cfg_data[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Clearing pass address
	logic [ADDR_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Source position and cell counters
	logic [SIZE_W-1:0] src_col_q, src_row_q;
	logic [STEP_W-1:0] col_phase_q, row_phase_q;
	logic [CX_W-1:0]   cell_x_q;
	logic [CY_W-1:0]   cell_y_q;
	logic [BASE_W-1:0] row_base_q;
	logic              col_wrap, row_wrap, col_step, row_step;

	assign col_wrap = ({1'b0, src_col_q} + 1'b1) >= {1'b0, image_width_q};
	assign row_wrap = ({1'b0, src_row_q} + 1'b1) >= {1'b0, image_height_q};
	assign col_step = ({1'b0, col_phase_q} + 1'b1) >= {1'b0, step_x_q};
	assign row_step = ({1'b0, row_phase_q} + 1'b1) >= {1'b0, step_y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q   <= '0;
			src_row_q   <= '0;
			col_phase_q <= '0;
			row_phase_q <= '0;
			cell_x_q    <= '0;
			cell_y_q    <= '0;
			row_base_q  <= '0;
		end else if (cmd.pix_wr) begin
			if (col_wrap) begin
				src_col_q   <= '0;
				col_phase_q <= '0;
				cell_x_q    <= '0;
				if (row_wrap) begin
					src_row_q   <= '0;
					row_phase_q <= '0;
					cell_y_q    <= '0;
					row_base_q  <= '0;
				end else begin
					src_row_q <= src_row_q + 1'b1;
					if (row_step) begin
						row_phase_q <= '0;
						if (cell_y_q < CY_W'(OUT_HEIGHT)) begin
							cell_y_q   <= cell_y_q + 1'b1;
							row_base_q <= row_base_q + BASE_W'(OUT_WIDTH);
						end
					end else begin
						row_phase_q <= row_phase_q + 1'b1;
					end
				end
			end else begin
				src_col_q <= src_col_q + 1'b1;
				if (col_step) begin
					col_phase_q <= '0;
					if (cell_x_q < CX_W'(OUT_WIDTH)) cell_x_q <= cell_x_q + 1'b1;
				end else begin
					col_phase_q <= col_phase_q + 1'b1;
				end
			end
		end
	end

	// Classify the pixel and decide on a store write
	cls_t              pix_cls;
	logic              pix_store;
	logic [BASE_W-1:0] pix_addr;

	always_comb begin
		if ((blue | green | red) == '0) begin
			pix_cls = CLS_BLACK;
		end else if ((blue & green & red) == '1) begin
			pix_cls = CLS_WHITE;
		end else begin
			pix_cls = CLS_GREY;
		end
	end

	assign pix_store = cmd.pix_wr && (col_phase_q == '0) && (row_phase_q == '0) &&
		(cell_x_q < CX_W'(OUT_WIDTH)) && (cell_y_q < CY_W'(OUT_HEIGHT));
	assign pix_addr  = row_base_q + BASE_W'(cell_x_q);

	// Drain walk over the store, top row first
	logic [ADDR_W-1:0] walk_addr_q;
	logic [COL_W-1:0]  walk_col_q;
	logic [BYTE_W-1:0] byte_q;
	logic [K_W-1:0]    k_q;
	logic              byte_last, digit_ok;

	assign byte_last   = (byte_q == BYTE_W'(NBYTES - 1));
	assign digit_ok    = !(byte_last && (k_q >= K_W'(LAST_DIGITS)));
	assign sts.rd_last = (k_q == K_W'(GROUP - 1));
	assign sts.clr_done = (clr_addr_q == ADDR_W'(CELLS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_addr_q <= WALK_START;
			walk_col_q  <= '0;
			byte_q      <= '0;
			k_q         <= '0;
		end else if (cmd.rd_en) begin
			k_q <= sts.rd_last ? '0 : k_q + 1'b1;
			if (digit_ok) begin
				if (walk_col_q == COL_W'(OUT_WIDTH - 1)) begin
					walk_col_q  <= '0;
					walk_addr_q <= walk_addr_q - ADDR_W'(2 * OUT_WIDTH - 1);
				end else begin
					walk_col_q  <= walk_col_q + 1'b1;
					walk_addr_q <= walk_addr_q + 1'b1;
				end
			end
		end else if (cmd.out_load) begin
			if (byte_last) begin
				byte_q      <= '0;
				walk_addr_q <= WALK_START;
				walk_col_q  <= '0;
			end else begin
				byte_q <= byte_q + 1'b1;
			end
		end
	end

	// Cell store
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [1:0]        ram_wdata, ram_rdata;

	assign ram_we    = cmd.clr_wr || pix_store;
	assign ram_waddr = cmd.clr_wr ? clr_addr_q : pix_addr[ADDR_W-1:0];
	assign ram_wdata = cmd.clr_wr ? CLS_BLACK : pix_cls;

	tpack_ram #(
		.WIDTH (2),
		.DEPTH (CELLS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (walk_addr_q),
		.rdata (ram_rdata)
	);

	// Track reads in flight
	logic           rd_vld_s1, ok_s1;
	logic [K_W-1:0] k_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		k_s1  <= k_q;
		ok_s1 <= digit_ok;
	end

	// Map class to digit
	logic [CODE_W-1:0] digit;

	always_comb begin
		if (!ok_s1) begin
			digit = clip_code(code_black_q);
		end else begin
			unique case (ram_rdata)
				CLS_WHITE: digit = clip_code(code_white_q);
				CLS_GREY:  digit = clip_code(code_grey_q);
				default:   digit = clip_code(code_black_q);
			endcase
		end
	end

	// Accumulate the base-3 word
	logic [BYTE_OUT_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (cmd.drn_start) begin
			acc_q <= '0;
		end else if (rd_vld_s1) begin
			acc_q <= acc_q + BYTE_OUT_W'(digit * weight_of(k_s1));
		end
	end

	// Output register
	logic out_valid_q;

	assign sts.out_busy = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [BYTE_OUT_W-1:0] packed_q;
	logic                  last_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			packed_q <= acc_q;
			last_q   <= byte_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign packed_byte = packed_q;
	assign last_byte   = last_q;

endmodule
`default_nettype wire

// File: src/pixel_frame_to_ternary_packer.sv
// Top level of the ternary frame packer: controller plus datapath.
//
// Pixel words (mode 0) arrive in bottom-up raster order; in every row picked
// by the vertical step, one pixel per horizontal step is classified black,
// white or grey and stored in an 80x30 cell grid, samples past the grid being
// dropped. Drain words (mode 1) each return one byte that packs five cell
// codes in base 3, top row first, with last_byte set on the 480th byte of the
// grid. Pixels stream at one per cycle while the block is idle, that is with
// no drain or clearing pass under way. A drain word makes five reads through
// the single read port of the cell store, waits in a settle state for the
// last read to land, then loads the output register in a push state, which
// waits while the output side stalls. After reset the block runs a clearing
// pass over every cell of the cell store before it takes its first word;
// configuration writes are taken throughout.
`default_nettype none
module pixel_frame_to_ternary_packer import tpack_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  mode,
	input  wire logic [CHAN_W-1:0]     blue,
	input  wire logic [CHAN_W-1:0]     green,
	input  wire logic [CHAN_W-1:0]     red,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [BYTE_OUT_W-1:0]      packed_byte,
	output logic                       last_byte
);

	cmd_t cmd;
	sts_t sts;

	// Sequence the clearing pass, pixel writes and drains
	tpack_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// Counters, cell store and packer
	tpack_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.blue        (blue),
		.green       (green),
		.red         (red),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.packed_byte (packed_byte),
		.last_byte   (last_byte)
	);

endmodule
`default_nettype wire
